@@ src/asfp_pkg.sv @@
// Shared types, character codes and token tables for the ASCII status frame parser.
`timescale 1ns / 1ps

package asfp_pkg;

	localparam int unsigned MAX_FRAME_LEN_DEF = 127;
	localparam int unsigned PREFIX_LEN_DEF    = 12;

	// Number of leading frame characters the decoder looks at ('$' plus eleven)
	localparam int unsigned VIEW_LEN  = 12;
	// Longest token after '$' (the flip start command)
	localparam int unsigned TOK_CHARS = 11;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_IDLE   = 8'h49; // 'I'
	localparam logic [7:0] CH_FLIP   = 8'h46; // 'F'
	localparam logic [7:0] CH_BAD    = 8'h42; // 'B'

	typedef logic [VIEW_LEN-1:0][7:0]  view_t;
	typedef logic [8*TOK_CHARS-1:0]    tok_t;

	// Tokens left-aligned, first character in the top byte
	localparam tok_t TOK_OK     = {"OK!", 64'h0};
	localparam tok_t TOK_BUSY   = {"BUSY!", 48'h0};
	localparam tok_t TOK_PONG   = {"PONG!", 48'h0};
	localparam tok_t TOK_FLIP   = {"FLIP", "_START!"};
	localparam tok_t TOK_BAD    = {"BAD", "_START!", 8'h0};
	localparam tok_t TOK_STOP   = {"STOPPED!", 24'h0};
	localparam tok_t TOK_DONE   = {"DONE!", 48'h0};
	localparam tok_t TOK_SENSOR = {"SENSOR:", 32'h0};
	localparam tok_t TOK_STATUS = {"STATUS:", 32'h0};

	localparam logic [3:0] LEN_OK     = 4'd3;
	localparam logic [3:0] LEN_BUSY   = 4'd5;
	localparam logic [3:0] LEN_PONG   = 4'd5;
	localparam logic [3:0] LEN_FLIP   = 4'd11;
	localparam logic [3:0] LEN_BAD    = 4'd10;
	localparam logic [3:0] LEN_STOP   = 4'd8;
	localparam logic [3:0] LEN_DONE   = 4'd5;
	localparam logic [3:0] LEN_REPORT = 4'd7;

	typedef enum logic [3:0] {
		RC_NONE   = 4'd0,
		RC_OK     = 4'd1,
		RC_BUSY   = 4'd2,
		RC_PONG   = 4'd3,
		RC_FLIP   = 4'd4,
		RC_BAD    = 4'd5,
		RC_STOP   = 4'd6,
		RC_DONE   = 4'd7,
		RC_SENSOR = 4'd8,
		RC_STATUS = 4'd9
	} resp_t;

	typedef struct packed {
		logic       sensor;
		logic       busy;
		logic [3:0] step;
		logic [7:0] seq_char;
	} cache_t;

	typedef struct packed {
		logic done;
		logic drop;
	} frame_evt_t;

	// True when the characters after '$' equal the first n characters of the token
	function automatic logic tok_match(view_t v, tok_t t, logic [3:0] n);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < TOK_CHARS; i++) begin
			if (i < int'(n) && v[i+1] != t[8*(TOK_CHARS-1-i) +: 8])
				ok = 1'b0;
		end
		return ok;
	endfunction

endpackage

@@ src/asfp_frame.sv @@
// Frame assembly: length count, stored prefix characters and the merged character view.
`timescale 1ns / 1ps

module asfp_frame
	import asfp_pkg::*;
#(
	parameter int unsigned MAX_FRAME_LEN = MAX_FRAME_LEN_DEF,
	parameter int unsigned PREFIX_LEN    = PREFIX_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] rx_byte,
	output view_t      view,
	output frame_evt_t evt
);

	localparam int unsigned LEN_W = $clog2(MAX_FRAME_LEN + 1);
	localparam int unsigned IDX_W = $clog2(PREFIX_LEN);

	logic [LEN_W-1:0] len_q;
	logic [7:0]       prefix_q [PREFIX_LEN];

	logic in_frame;
	logic room;
	logic store;

	assign in_frame = (len_q != '0) || (rx_byte == CH_DOLLAR);
	assign room     = (len_q != LEN_W'(MAX_FRAME_LEN));
	assign store    = in_frame && room;

	assign evt.done = store && (rx_byte == CH_BANG);
	assign evt.drop = in_frame && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (en) begin
			if (evt.done || evt.drop)
				len_q <= '0;
			else if (store)
				len_q <= len_q + LEN_W'(1);
		end
	end

	// Entries at or past the length count are treated as empty, so no clear is needed
	always_ff @(posedge clk) begin
		if (en && store && (32'(len_q) < PREFIX_LEN))
			prefix_q[len_q[IDX_W-1:0]] <= rx_byte;
	end

	// Frame contents as they stand once this byte is stored
	always_comb begin
		for (int i = 0; i < VIEW_LEN; i++) begin
			if (32'(len_q) > i)
				view[i] = prefix_q[i];
			else if (32'(len_q) == i)
				view[i] = rx_byte;
			else
				view[i] = 8'h00;
		end
	end

endmodule

@@ src/asfp_decode.sv @@
// Token matcher and cached status update for a completed frame.
`timescale 1ns / 1ps

module asfp_decode
	import asfp_pkg::*;
(
	input  view_t  view,
	input  cache_t cur,
	output resp_t  code,
	output cache_t nxt
);

	logic [7:0] digit;

	assign digit = view[10];

	always_comb begin
		code = RC_NONE;
		nxt  = cur;
		if (view[0] != CH_DOLLAR) begin
			code = RC_NONE;
		end else if (tok_match(view, TOK_OK, LEN_OK)) begin
			code = RC_OK;
		end else if (tok_match(view, TOK_BUSY, LEN_BUSY)) begin
			code = RC_BUSY;
		end else if (tok_match(view, TOK_PONG, LEN_PONG)) begin
			code = RC_PONG;
		end else if (tok_match(view, TOK_FLIP, LEN_FLIP)) begin
			code         = RC_FLIP;
			nxt.busy     = 1'b1;
			nxt.seq_char = CH_FLIP;
			nxt.step     = 4'd1;
		end else if (tok_match(view, TOK_BAD, LEN_BAD)) begin
			code         = RC_BAD;
			nxt.busy     = 1'b1;
			nxt.seq_char = CH_BAD;
			nxt.step     = 4'd1;
		end else if (tok_match(view, TOK_STOP, LEN_STOP)) begin
			code         = RC_STOP;
			nxt.busy     = 1'b0;
			nxt.seq_char = CH_IDLE;
			nxt.step     = 4'd0;
		end else if (tok_match(view, TOK_DONE, LEN_DONE)) begin
			code         = RC_DONE;
			nxt.busy     = 1'b0;
			nxt.seq_char = CH_IDLE;
			nxt.step     = 4'd0;
		end else if (tok_match(view, TOK_SENSOR, LEN_REPORT)) begin
			code       = RC_SENSOR;
			nxt.sensor = (view[8] == CH_ONE);
		end else if (tok_match(view, TOK_STATUS, LEN_REPORT)) begin
			code         = RC_STATUS;
			nxt.seq_char = view[8];
			if (view[9] == CH_COMMA && digit >= CH_ZERO && digit <= CH_NINE)
				nxt.step = 4'(digit - CH_ZERO);
			if (view[8] == CH_IDLE) begin
				nxt.busy = 1'b0;
				nxt.step = 4'd0;
			end else begin
				nxt.busy = 1'b1;
			end
		end
	end

endmodule

@@ src/ascii_status_frame_parser.sv @@
// Top level of the ASCII status frame parser: input register, frame state and result register.
`timescale 1ns / 1ps

// ASCII status frame parser. Takes one received UART character per transfer
// and returns exactly one result transfer per character. Outside a frame every
// character other than '$' is ignored; '$' opens a frame that runs to '!'.
// On '!' the frame is matched against OK, BUSY, PONG, the flip and bad start
// commands, STOPPED, DONE, SENSOR:x and STATUS:c,d, the cached
// sensor/busy/step/type state is updated and response_code reports the match
// (0 if none). A frame that already holds MAX_FRAME_LEN characters is dropped
// on the next character, which sets overflow_drop. The cached fields on every
// result show the state after that character. Rate: one character per clock,
// sustained while out_stall does not hold a full result register; each character
// passes the input register, then frame logic and token compare into the result
// register.
// Both registers hold under out_stall, so in_stall rises only when the
// result register is full and stalled. No start-up pass after reset.

module ascii_status_frame_parser
	import asfp_pkg::*;
#(
	parameter int unsigned MAX_FRAME_LEN = MAX_FRAME_LEN_DEF,
	parameter int unsigned PREFIX_LEN    = PREFIX_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,

	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,

	output logic       out_valid,
	input  logic       out_stall,
	output logic       frame_done,
	output logic [3:0] response_code,
	output logic       overflow_drop,
	output logic       sensor_present,
	output logic       sequence_busy,
	output logic [3:0] sequence_step,
	output logic [7:0] sequence_char
);

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Cached status and result register
	cache_t     cache_q;
	logic       out_valid_q;
	logic       done_q;
	resp_t      code_q;
	logic       drop_q;
	cache_t     res_cache_q;

	logic       adv;      // result register free or being emptied
	logic       en;       // a character is processed this cycle
	view_t      view;
	frame_evt_t evt;
	resp_t      dec_code;
	cache_t     dec_nxt;
	cache_t     cache_nxt;

	assign adv      = !out_valid_q || !out_stall;
	assign en       = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			byte_s1 <= rx_byte;
	end

	asfp_frame #(
		.MAX_FRAME_LEN(MAX_FRAME_LEN),
		.PREFIX_LEN   (PREFIX_LEN)
	) u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.rx_byte(byte_s1),
		.view   (view),
		.evt    (evt)
	);

	asfp_decode u_decode (
		.view(view),
		.cur (cache_q),
		.code(dec_code),
		.nxt (dec_nxt)
	);

	// Cached state only moves on a completed frame
	assign cache_nxt = evt.done ? dec_nxt : cache_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_q <= '{sensor: 1'b0, busy: 1'b0, step: 4'd0, seq_char: CH_IDLE};
		end else if (en) begin
			cache_q <= cache_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			done_q      <= evt.done;
			code_q      <= evt.done ? dec_code : RC_NONE;
			drop_q      <= evt.drop;
			res_cache_q <= cache_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign frame_done     = done_q;
	assign response_code  = code_q;
	assign overflow_drop  = drop_q;
	assign sensor_present = res_cache_q.sensor;
	assign sequence_busy  = res_cache_q.busy;
	assign sequence_step  = res_cache_q.step;
	assign sequence_char  = res_cache_q.seq_char;

`ifndef NO_ASSERTIONS
	// A character cannot both close a frame and overflow it
	a_done_drop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(frame_done && overflow_drop))
		else $error("frame_done and overflow_drop both set");

	// A response code only comes with a closed frame
	a_code_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && response_code != RC_NONE) |-> frame_done)
		else $error("response code without frame_done");

	// Idle sequence never carries a step number
	a_idle_step_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!cache_q.busy |-> cache_q.step == 4'd0)
		else $error("step set while not busy");

	// Busy flag and idle type character agree
	a_idle_char: assert property (@(posedge clk) disable iff (!arst_n)
		cache_q.busy != (cache_q.seq_char == CH_IDLE))
		else $error("busy flag disagrees with sequence character");

	// Input register never advances while its character is held back
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1 && $stable(byte_s1))
		else $error("input register lost a held character");
`endif

endmodule
